// File: sv/uart_rx_idle_packetizer_defines.svh
// Assertion macros shared by the checker of the serial receive packetiser.
// Depends on nothing; included by the files that hold assertions.
`ifndef UART_RX_IDLE_PACKETIZER_DEFINES_SVH
`define UART_RX_IDLE_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urip: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define URIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urip: next-cycle check failed");

`endif

// File: sv/urip_pkg.sv
// Shared types, constants and helpers for the serial receive packetiser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package urip_pkg;

  localparam int RX_DEPTH    = 64;
  localparam int RX_AW       = $clog2(RX_DEPTH);
  localparam int FILL_W      = $clog2(RX_DEPTH + 1);
  localparam int BURST_LEN   = 32;
  localparam int SPLIT_LEN   = 32;
  localparam int BLEN_W      = $clog2(BURST_LEN + 1);
  localparam int FULL_THRESH = 31;
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_AW       = $clog2(CQ_DEPTH);
  localparam int CQ_CW       = $clog2(CQ_DEPTH + 1);

  localparam logic [7:0] TICKS_MAX        = 8'hFF;
  localparam logic [7:0] IDLE_TIMEOUT_RST = 8'd1;

  // Input kind codes
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;
  localparam logic [1:0] KIND_RESV = 2'd3;

  // Fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_LINE = 2'd1;
  localparam logic [1:0] FAULT_OVFL = 2'd2;

  // Register index of idle_timeout
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       line_error;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic       end_of_service;
    logic [1:0] fault_code;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       err;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // Bytes one flush takes from a store holding fill bytes.
  function automatic logic [BLEN_W-1:0] burst_take(input logic [FILL_W-1:0] fill);
    logic [BLEN_W-1:0] res;
    if (fill > FILL_W'(BURST_LEN)) begin
      res = BLEN_W'(BURST_LEN);
    end else begin
      res = BLEN_W'(fill);
    end
    return res;
  endfunction

endpackage

// File: sv/urip_front.sv
// Front end: takes input words, drops the undefined kind and queues commands.
// Depends on urip_pkg.
`timescale 1ns / 1ps

module urip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  urip_pkg::in_item_t  in_data,
  output logic                busy,
  input  logic                pop,
  output urip_pkg::cmd_slot_t head
);

  urip_pkg::cmd_t                   slots_r [urip_pkg::CQ_DEPTH];
  logic [urip_pkg::CQ_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [urip_pkg::CQ_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [urip_pkg::CQ_CW-1:0]       cnt_r, cnt_nxt;
  logic                             push;
  logic                             do_pop;
  urip_pkg::cmd_t                   cmd_in;

  assign busy = (cnt_r == urip_pkg::CQ_CW'(urip_pkg::CQ_DEPTH));

  // A word of the undefined kind is taken and then discarded here.
  assign push   = start && !busy && (in_data.kind != urip_pkg::KIND_RESV);
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    cmd_in.kind = in_data.kind;
    cmd_in.data = in_data.rx_byte;
    cmd_in.err  = in_data.line_error;
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == urip_pkg::CQ_AW'(urip_pkg::CQ_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == urip_pkg::CQ_AW'(urip_pkg::CQ_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + urip_pkg::CQ_CW'(push) - urip_pkg::CQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: sv/urip_back.sv
// Back end: receive store, idle counter, fault record and the flush sequencer.
// Depends on urip_pkg; fed by urip_front.
`timescale 1ns / 1ps

module urip_back (
  input  logic                clk,
  input  logic                rst_n,
  input  urip_pkg::cmd_slot_t head,
  output logic                pop,
  input  logic [7:0]          idle_timeout,
  output logic                out_valid,
  output urip_pkg::out_item_t out_data
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic [7:0]                    rx_store_r [urip_pkg::RX_DEPTH];
  logic [7:0]                    rd_data_r;

  logic                          state_r, state_nxt;
  logic [urip_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [urip_pkg::RX_AW-1:0]    wp_r, wp_nxt;
  logic [urip_pkg::RX_AW-1:0]    rp_r, rp_nxt;
  logic [7:0]                    ticks_r, ticks_nxt;
  logic                          running_r, running_nxt;
  logic [1:0]                    fault_r, fault_nxt;
  logic [1:0]                    fhold_r, fhold_nxt;
  logic [urip_pkg::BLEN_W-1:0]   cur_len_r, cur_len_nxt;
  logic [urip_pkg::BLEN_W-1:0]   next_len_r, next_len_nxt;
  logic [urip_pkg::BLEN_W-1:0]   idx_r, idx_nxt;

  logic                          ov_r, ov_nxt;
  logic                          oisd_r, oisd_nxt;
  logic                          oeop_r, oeop_nxt;
  logic                          oeos_r, oeos_nxt;
  logic [1:0]                    ofc_r, ofc_nxt;

  logic                          wr_en;
  logic                          rd_en;
  logic [urip_pkg::BLEN_W-1:0]   len1, len2;
  logic [urip_pkg::FILL_W-1:0]   rem;
  logic                          timed_out;
  logic                          last;

  always_comb begin
    len1      = (fill_r > urip_pkg::FILL_W'(urip_pkg::FULL_THRESH)) ?
                urip_pkg::burst_take(fill_r) : '0;
    rem       = fill_r - urip_pkg::FILL_W'(len1);
    timed_out = (ticks_r > idle_timeout);
    len2      = timed_out ? urip_pkg::burst_take(rem) : '0;
    last      = (idx_r == cur_len_r - 1'b1);
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    ticks_nxt    = ticks_r;
    running_nxt  = running_r;
    fault_nxt    = fault_r;
    fhold_nxt    = fhold_r;
    cur_len_nxt  = cur_len_r;
    next_len_nxt = next_len_r;
    idx_nxt      = idx_r;
    ov_nxt       = 1'b0;
    oisd_nxt     = 1'b0;
    oeop_nxt     = 1'b0;
    oeos_nxt     = 1'b0;
    ofc_nxt      = urip_pkg::FAULT_NONE;
    pop          = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.cmd.kind)
            urip_pkg::KIND_BYTE: begin
              if (head.cmd.err) begin
                fault_nxt = urip_pkg::FAULT_LINE;
              end else if (fill_r < urip_pkg::FILL_W'(urip_pkg::RX_DEPTH)) begin
                wr_en       = 1'b1;
                wp_nxt      = (wp_r == urip_pkg::RX_AW'(urip_pkg::RX_DEPTH - 1)) ? '0 :
                              wp_r + 1'b1;
                fill_nxt    = fill_r + 1'b1;
                running_nxt = 1'b1;
                ticks_nxt   = '0;
              end else begin
                fault_nxt = urip_pkg::FAULT_OVFL;
              end
            end
            urip_pkg::KIND_TICK: begin
              if (running_r && (ticks_r != urip_pkg::TICKS_MAX)) begin
                ticks_nxt = ticks_r + 1'b1;
              end
            end
            urip_pkg::KIND_POLL: begin
              fill_nxt  = rem - urip_pkg::FILL_W'(len2);
              fault_nxt = urip_pkg::FAULT_NONE;
              if (timed_out) begin
                running_nxt = 1'b0;
              end
              if ((len1 == '0) && (len2 == '0)) begin
                // Nothing to flush: a status-only word closes the service.
                ov_nxt   = 1'b1;
                oeos_nxt = 1'b1;
                ofc_nxt  = fault_r;
              end else begin
                fhold_nxt    = fault_r;
                cur_len_nxt  = (len1 != '0) ? len1 : len2;
                next_len_nxt = (len1 != '0) ? len2 : '0;
                idx_nxt      = '0;
                state_nxt    = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FLUSH: begin
        rd_en    = 1'b1;
        rp_nxt   = (rp_r == urip_pkg::RX_AW'(urip_pkg::RX_DEPTH - 1)) ? '0 : rp_r + 1'b1;
        ov_nxt   = 1'b1;
        oisd_nxt = 1'b1;
        // A flush of exactly the split length closes a packet half way through.
        oeop_nxt = last ||
                   ((cur_len_r == urip_pkg::BLEN_W'(urip_pkg::SPLIT_LEN)) &&
                    (idx_r == urip_pkg::BLEN_W'(urip_pkg::SPLIT_LEN / 2 - 1)));
        oeos_nxt = last && (next_len_r == '0);
        ofc_nxt  = (last && (next_len_r == '0)) ? fhold_r : urip_pkg::FAULT_NONE;
        if (last) begin
          if (next_len_r != '0) begin
            cur_len_nxt  = next_len_r;
            next_len_nxt = '0;
            idx_nxt      = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rx_store_r[wp_r] <= head.cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= rx_store_r[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      wp_r       <= '0;
      rp_r       <= '0;
      ticks_r    <= '0;
      running_r  <= 1'b0;
      fault_r    <= urip_pkg::FAULT_NONE;
      fhold_r    <= urip_pkg::FAULT_NONE;
      cur_len_r  <= '0;
      next_len_r <= '0;
      idx_r      <= '0;
      ov_r       <= 1'b0;
      oisd_r     <= 1'b0;
      oeop_r     <= 1'b0;
      oeos_r     <= 1'b0;
      ofc_r      <= urip_pkg::FAULT_NONE;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      ticks_r    <= ticks_nxt;
      running_r  <= running_nxt;
      fault_r    <= fault_nxt;
      fhold_r    <= fhold_nxt;
      cur_len_r  <= cur_len_nxt;
      next_len_r <= next_len_nxt;
      idx_r      <= idx_nxt;
      ov_r       <= ov_nxt;
      oisd_r     <= oisd_nxt;
      oeop_r     <= oeop_nxt;
      oeos_r     <= oeos_nxt;
      ofc_r      <= ofc_nxt;
    end
  end

  assign out_valid               = ov_r;
  assign out_data.is_data        = oisd_r;
  assign out_data.data_byte      = oisd_r ? rd_data_r : 8'd0;
  assign out_data.end_of_packet  = oeop_r;
  assign out_data.end_of_service = oeos_r;
  assign out_data.fault_code     = ofc_r;

endmodule

// File: sv/uart_rx_idle_packetizer.sv
// Top level of the serial receive packetiser: register port, front and back.
// Depends on urip_pkg, urip_front and urip_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   input    | start / busy           | in_data  (urip_pkg::in_item_t)
//   result   | out_valid strobe       | out_data (urip_pkg::out_item_t)
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata
//
// A received byte or a timer tick is handled by the back end while it is idle.
// A service poll is planned in the idle state and then flushes one byte per
// cycle (up to 64), paced by the single read port of the receive store; a poll
// that flushes nothing gives its status word in the cycle after planning. Words
// wait in a two-entry command queue; busy is high while it is full. Reset clears
// all control state at once; the store contents are undefined until written.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module uart_rx_idle_packetizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  urip_pkg::in_item_t  in_data,
  output logic                busy,
  output logic                out_valid,
  output urip_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]          idle_timeout_r;
  logic                cfg_wr;
  logic                pop;
  urip_pkg::cmd_slot_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= urip_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_wr && (paddr[2] == urip_pkg::REG_IDLE_TIMEOUT)) begin
      idle_timeout_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == urip_pkg::REG_IDLE_TIMEOUT) ? {24'd0, idle_timeout_r} : 32'd0;

  urip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .pop     (pop),
    .head    (head)
  );

  urip_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .idle_timeout (idle_timeout_r),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

// File: sv/urip_checker.sv
// Port-level checks on the result stream of the serial receive packetiser.
// Depends on urip_pkg and uart_rx_idle_packetizer_defines.svh; bound to the top.
`timescale 1ns / 1ps
`include "uart_rx_idle_packetizer_defines.svh"

module urip_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input urip_pkg::out_item_t out_data
);

  // The words of one service leave in consecutive cycles.
  `URIP_ASSERT_NEXT(a_service_contiguous, out_valid && !out_data.end_of_service, out_valid)

  // A status-only word is always the last of its service.
  `URIP_ASSERT_NOW(a_status_is_final, out_valid && !out_data.is_data, out_data.end_of_service && !out_data.end_of_packet && (out_data.data_byte == 8'd0))

  // The final data word of a service also closes its packet.
  `URIP_ASSERT_NOW(a_final_closes_packet, out_valid && out_data.is_data && out_data.end_of_service, out_data.end_of_packet)

  // A fault is only reported on the final word.
  `URIP_ASSERT_NOW(a_fault_on_final, out_valid && !out_data.end_of_service, out_data.fault_code == urip_pkg::FAULT_NONE)

endmodule

bind uart_rx_idle_packetizer urip_checker u_urip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: bench/uart_rx_idle_packetizer_tb.sv
// Self-checking bench for the serial receive packetiser: a directed table, then random traffic.
// Depends on urip_pkg and uart_rx_idle_packetizer. Predicted words are compared field by field
// with the block's output.
`timescale 1ns / 1ps

module uart_rx_idle_packetizer_tb;
  import urip_pkg::*;

  localparam logic [2:0] ADDR_IDLE_TIMEOUT = 3'(4 * REG_IDLE_TIMEOUT);
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
  localparam int         SETTLE_CYCLES     = 16;
  localparam int         PHASE_ITEMS       = 20;
  localparam int         SAT_TICKS         = 20;

  typedef struct {
    in_item_t  w;
    int        reps;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  in_item_t    in_data;
  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the packetiser.
  logic [7:0]        rx_copy [RX_DEPTH];
  logic [RX_AW-1:0]  rd_pos;
  logic [RX_AW-1:0]  wr_pos;
  logic [FILL_W-1:0] fill;
  logic [7:0]        ticks;
  logic              ticking;
  logic [1:0]        fault;
  logic [7:0]        idle_to;

  out_item_t words_due[$];
  plan_row_t plan[$];
  int        failures = 0;
  bit        steady = 1'b0;

  uart_rx_idle_packetizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[uart_rx_idle_packetizer] ERROR");
    $finish;
  end

  function automatic out_item_t status_word(input logic [1:0] f);
    out_item_t s;
    s = '0;
    s.end_of_service = 1'b1;
    s.fault_code = f;
    return s;
  endfunction

  // Takes up to one burst from the store copy, splitting a flush of exactly SPLIT_LEN in half.
  task automatic flush_packet();
    int take;
    int half;
    out_item_t o;
    take = (fill < BURST_LEN) ? int'(fill) : BURST_LEN;
    half = (take == SPLIT_LEN) ? SPLIT_LEN / 2 : 0;
    for (int i = 0; i < take; i++) begin
      o = '0;
      o.is_data = 1'b1;
      o.data_byte = rx_copy[rd_pos];
      o.end_of_packet = (i + 1 == take) || (half != 0 && i + 1 == half);
      rd_pos = rd_pos + 1'b1;
      words_due.push_back(o);
    end
    fill = fill - FILL_W'(take);
  endtask

  task automatic packetize(input in_item_t w);
    int base;
    out_item_t last;
    case (w.kind)
      KIND_BYTE: begin
        if (w.line_error) begin
          fault = FAULT_LINE;
        end else if (fill < RX_DEPTH) begin
          ticking = 1'b1;
          ticks = '0;
          rx_copy[wr_pos] = w.rx_byte;
          wr_pos = wr_pos + 1'b1;
          fill = fill + 1'b1;
        end else begin
          fault = FAULT_OVFL;
        end
      end
      KIND_TICK: begin
        if (ticking && ticks != TICKS_MAX) ticks = ticks + 1'b1;
      end
      KIND_POLL: begin
        base = words_due.size();
        if (fill > FULL_THRESH) flush_packet();
        if (ticks > idle_to) begin
          ticking = 1'b0;
          flush_packet();
        end
        if (words_due.size() == base) words_due.push_back('0);
        last = words_due.pop_back();
        last.end_of_service = 1'b1;
        last.fault_code = fault;
        words_due.push_back(last);
        fault = FAULT_NONE;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (words_due.size() == 0) begin
      $error("unexpected word %h", got);
      failures++;
    end else begin
      want = words_due.pop_front();
      if (got.is_data !== want.is_data) begin
        $error("is_data: expected %0d, got %0d", want.is_data, got.is_data);
        failures++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
        failures++;
      end
      if (got.end_of_packet !== want.end_of_packet) begin
        $error("end_of_packet: expected %0d, got %0d", want.end_of_packet, got.end_of_packet);
        failures++;
      end
      if (got.end_of_service !== want.end_of_service) begin
        $error("end_of_service: expected %0d, got %0d", want.end_of_service,
               got.end_of_service);
        failures++;
      end
      if (got.fault_code !== want.fault_code) begin
        $error("fault_code: expected %0d, got %0d", want.fault_code, got.fault_code);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) check_word(out_data);
  end

  // Offers one word after a random gap and returns at the edge that accepts it; start is left
  // high so that a back-to-back word needs no second assignment in the same step.
  task automatic send(input in_item_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    packetize(w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_timeout_reg();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_IDLE_TIMEOUT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, idle_to}) begin
      $error("idle_timeout: expected %0d, got %0d", idle_to, prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register while the block is idle, then reads the timeout back.
  task automatic set_timeout(input logic [2:0] addr, input logic [7:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_IDLE_TIMEOUT) idle_to = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= '0;
    @(posedge clk);
    check_timeout_reg();
  endtask

  function automatic void add_row(input logic [1:0] kind, input logic [7:0] b,
                                  input logic err, input int reps, input bit typed,
                                  input out_item_t want);
    plan_row_t row;
    row.w.kind = kind;
    row.w.rx_byte = b;
    row.w.line_error = err;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  // A run of bytes, some ticks and up to two polls, with noise words and the odd broken run.
  task automatic random_run(inout int count);
    int nb;
    int nt;
    int np;
    in_item_t w;
    steady = ($urandom_range(0, 3) == 0);
    nb = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
    for (int k = 0; k < nb; k++) begin
      w.kind = KIND_BYTE;
      w.rx_byte = 8'($urandom_range(0, 255));
      w.line_error = ($urandom_range(0, 15) == 0);
      send(w);
      count++;
      if ($urandom_range(0, 19) == 0) begin
        w.kind = KIND_RESV;
        w.rx_byte = 8'($urandom_range(0, 255));
        w.line_error = 1'($urandom_range(0, 1));
        send(w);
      end
    end
    nt = $urandom_range(0, 4) + ((idle_to < 8) ? int'(idle_to) : 0);
    for (int k = 0; k < nt; k++) begin
      w.kind = KIND_TICK;
      w.rx_byte = 8'($urandom_range(0, 255));
      w.line_error = 1'($urandom_range(0, 1));
      send(w);
      count++;
    end
    np = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 4) == 0) ? 2 : 1);
    for (int k = 0; k < np; k++) begin
      w.kind = KIND_POLL;
      w.rx_byte = 8'($urandom_range(0, 255));
      w.line_error = 1'($urandom_range(0, 1));
      send(w);
      count++;
    end
  endtask

  initial begin
    in_item_t w;
    int count;
    start <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;

    rd_pos = '0;
    wr_pos = '0;
    fill = '0;
    ticks = '0;
    ticking = 1'b0;
    fault = FAULT_NONE;
    idle_to = IDLE_TIMEOUT_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_timeout_reg();

    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b1, status_word(FAULT_NONE));
    add_row(KIND_BYTE, 8'h00, 1'b1, 1, 1'b0, '0);
    add_row(KIND_POLL, 8'hFF, 1'b1, 1, 1'b1, status_word(FAULT_LINE));
    add_row(KIND_RESV, 8'hFF, 1'b1, 1, 1'b0, '0);
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b1, status_word(FAULT_NONE));
    add_row(KIND_BYTE, 8'hFF, 1'b0, 1, 1'b0, '0);
    add_row(KIND_BYTE, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(KIND_TICK, 8'h00, 1'b0, 1, 1'b0, '0);
    // One tick does not exceed the reset timeout, so only the status word leaves.
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b1, status_word(FAULT_NONE));
    add_row(KIND_TICK, 8'hFF, 1'b1, 1, 1'b0, '0);
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b0, '0);
    // The stopped counter still exceeds the timeout, but the store is empty.
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b1, status_word(FAULT_NONE));
    add_row(KIND_TICK, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(KIND_BYTE, 8'h80, 1'b0, RX_DEPTH, 1'b0, '0);
    add_row(KIND_BYTE, 8'h5A, 1'b0, 1, 1'b0, '0);
    add_row(KIND_BYTE, 8'h11, 1'b1, 1, 1'b0, '0);
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(KIND_BYTE, 8'h40, 1'b0, 10, 1'b0, '0);
    add_row(KIND_TICK, 8'h00, 1'b0, 3, 1'b0, '0);
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(KIND_BYTE, 8'hC3, 1'b0, 32, 1'b0, '0);
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(KIND_BYTE, 8'h7E, 1'b0, 31, 1'b0, '0);
    add_row(KIND_TICK, 8'h00, 1'b0, 2, 1'b0, '0);
    add_row(KIND_POLL, 8'h00, 1'b0, 1, 1'b0, '0);

    foreach (plan[i]) begin
      steady = ($urandom_range(0, 2) == 0);
      for (int r = 0; r < plan[i].reps; r++) begin
        w = plan[i].w;
        w.rx_byte = plan[i].w.rx_byte + 8'(r);
        send(w);
        // Typed rows are single-word polls: the typed word stands in for the predicted one.
        if (plan[i].typed) begin
          void'(words_due.pop_back());
          words_due.push_back(plan[i].want);
        end
      end
    end

    set_timeout(ADDR_IDLE_TIMEOUT, 8'd0);
    count = 0;
    while (count < PHASE_ITEMS) random_run(count);

    // With the largest timeout the counter never fires; once lowered below the count it does.
    set_timeout(ADDR_IDLE_TIMEOUT, 8'd255);
    w = '0;
    w.kind = KIND_BYTE;
    w.rx_byte = 8'h3C;
    send(w);
    w.kind = KIND_TICK;
    for (int k = 0; k < SAT_TICKS; k++) send(w);
    w.kind = KIND_POLL;
    send(w);
    set_timeout(ADDR_IDLE_TIMEOUT, 8'(SAT_TICKS - 1));
    send(w);
    count = 0;
    while (count < PHASE_ITEMS) random_run(count);

    set_timeout(ADDR_UNMAPPED, 8'($urandom_range(0, 255)));
    set_timeout(ADDR_IDLE_TIMEOUT, 8'($urandom_range(2, 12)));
    count = 0;
    while (count < PHASE_ITEMS) random_run(count);

    set_timeout(ADDR_IDLE_TIMEOUT, 8'd1);
    count = 0;
    while (count < PHASE_ITEMS) random_run(count);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && words_due.size() == 0) begin
      $display("[uart_rx_idle_packetizer] OK");
    end else begin
      $display("[uart_rx_idle_packetizer] ERROR");
    end
    $finish;
  end

endmodule
